/* sv/piecewise_linear_calibration_table_core_macros.svh */
// Assertion macros for the calibration table core
`ifndef PIECEWISE_LINEAR_CALIBRATION_TABLE_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_CALIBRATION_TABLE_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define PLCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PLCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/plct_pkg.sv */
// ----------------------------------------------------------------------------
// plct_pkg
// Types, codes and preset curves of the calibration table core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package plct_pkg;
  localparam int MaxPoints = 16;
  localparam int MinPoints = 2;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpA2d    = 2'd1;
  localparam logic [1:0] OpD2a    = 2'd2;
  localparam logic [1:0] OpPreset = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StRange   = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] distance;
    logic [15:0] adc_value;
    logic [2:0]  preset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic [4:0]  point_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_req;   // capture request
    logic       clr_idx;    // index := 0
    logic       inc_idx;    // index += 1
    logic       dec_idx;    // index -= 1
    logic       shift_wr;   // entry[idx] := entry[idx-1]
    logic       slot_wr;    // entry[idx] := request point
    logic       adc_wr;     // adc[idx] := request adc
    logic       preset_wr;  // entry[idx] := preset point
    logic       set_cnt_pre;
    logic       inc_cnt;
    logic       seg_load;   // latch segment idx, idx+1
    logic       mul_go;
    logic       div_init;
    logic       div_step;
    logic       rsp_load;
    logic [1:0] rsp_status;
    logic       rsp_use_val;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       preset_bad;
    logic       idx_ge_cnt;   // idx >= count
    logic       idx_last;     // idx + 1 >= count
    logic       dist_ge;      // dist[idx] >= request distance
    logic       dist_eq;
    logic       full;
    logic       cnt_bad;
    logic       pair_bad;     // entries idx-1, idx not monotonic
    logic       bracket;      // segment idx, idx+1 holds input
    logic       pre_done;     // idx + 1 >= preset length
    logic       div_done;
  } stat_t;

  function automatic logic [31:0] preset_point(input logic [1:0] p, input logic [2:0] i);
    logic [31:0] t [4][8];
    t[0] = '{{16'd100,16'd3580},{16'd150,16'd2500},{16'd200,16'd1900},{16'd250,16'd1500},
             {16'd300,16'd1250},{16'd400,16'd950},{16'd500,16'd780},{16'd800,16'd480}};
    t[1] = '{{16'd200,16'd3200},{16'd300,16'd2200},{16'd400,16'd1600},{16'd500,16'd1250},
             {16'd600,16'd1050},{16'd800,16'd800},{16'd1000,16'd650},{16'd1500,16'd450}};
    t[2] = '{{16'd40,16'd3800},{16'd60,16'd3200},{16'd80,16'd2700},{16'd100,16'd2300},
             {16'd150,16'd1700},{16'd300,16'd900},{16'd0,16'd0},{16'd0,16'd0}};
    t[3] = '{{16'd20,16'd3900},{16'd30,16'd3500},{16'd50,16'd2900},{16'd70,16'd2400},
             {16'd100,16'd1800},{16'd150,16'd1200},{16'd0,16'd0},{16'd0,16'd0}};
    return t[p][i];
  endfunction

  function automatic logic [3:0] preset_len(input logic [1:0] p);
    return (p[1]) ? 4'd6 : 4'd8;
  endfunction
endpackage

/* sv/plct_datapath.sv */
// ----------------------------------------------------------------------------
// plct_datapath
// Point table, index, segment registers, multiplier and serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plct_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plct_pkg::req_t req_i,
  input  plct_pkg::cmd_t cmd_i,
  output plct_pkg::stat_t stat_o,
  output plct_pkg::rsp_t rsp_o
);
  import plct_pkg::*;

  localparam int QW = 32;

  logic [15:0] dist_q [MaxPoints];
  logic [15:0] adc_q  [MaxPoints];
  req_t        req_q;
  logic [CntW-1:0] cnt_q, idx_q;
  logic [CntW-1:0] cnt_d;
  logic [IdxW-1:0] ia, ib;
  logic [15:0] s_in_q, s_out_q, e_in_q, e_out_q, x_q;
  logic        neg_q;           // sign of quotient
  logic [31:0] num_q;           // |product|
  logic [16:0] den_q;           // |e_in - s_in|
  logic [31:0] quo_q;
  logic [32:0] rem_q;
  logic [5:0]  dcnt_q;
  rsp_t        rsp_q;
  logic        to_dist;
  logic [15:0] x_w, cur_in, nxt_in, cur_out, nxt_out;
  logic [16:0] d_out, d_in;
  logic signed [17:0] dout_s;
  logic [31:0] res_abs;
  logic signed [33:0] r_s;
  logic [15:0] val;
  logic [31:0] ppt;
  logic [32:0] rem_sh;

  assign ia = idx_q[IdxW-1:0];
  assign ib = ia - IdxW'(1);
  assign to_dist = (req_q.opcode == OpA2d);
  assign x_w = to_dist ? req_q.adc_value : req_q.distance;
  assign ppt = preset_point(req_q.preset[1:0], idx_q[2:0]);

  // axis views of entry idx and idx+1 (for the segment scan)
  always_comb begin
    logic [IdxW-1:0] in_;
    in_ = ia + IdxW'(1);
    cur_in  = to_dist ? adc_q[ia]   : dist_q[ia];
    nxt_in  = to_dist ? adc_q[in_]  : dist_q[in_];
    cur_out = to_dist ? dist_q[ia]  : adc_q[ia];
    nxt_out = to_dist ? dist_q[in_] : adc_q[in_];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.shift_wr) begin
      dist_q[ia] <= dist_q[ib];
      adc_q[ia]  <= adc_q[ib];
    end
    if (cmd_i.slot_wr) begin
      dist_q[ia] <= req_q.distance;
      adc_q[ia]  <= req_q.adc_value;
    end
    if (cmd_i.adc_wr) adc_q[ia] <= req_q.adc_value;
    if (cmd_i.preset_wr) begin
      dist_q[ia] <= ppt[31:16];
      adc_q[ia]  <= ppt[15:0];
    end
    if (cmd_i.seg_load) begin
      s_in_q <= cur_in; e_in_q <= nxt_in;
      s_out_q <= cur_out; e_out_q <= nxt_out;
      x_q <= x_w;
    end
  end

  // count after this beat, so the result carries the updated value
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.set_cnt_pre) cnt_d = CntW'(preset_len(req_q.preset[1:0]));
    else if (cmd_i.inc_cnt) cnt_d = cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      rsp_q <= '0;
    end else begin
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + CntW'(1);
      else if (cmd_i.dec_idx) idx_q <= idx_q - CntW'(1);
      cnt_q <= cnt_d;
      if (cmd_i.rsp_load) begin
        rsp_q.status <= cmd_i.rsp_status;
        rsp_q.value  <= cmd_i.rsp_use_val ? val : 16'd0;
        rsp_q.point_count <= 5'(cnt_d);
      end
    end
  end

  // out - s_out as signed, |x - s_in| works since x lies in segment
  assign dout_s = $signed({2'b00, e_out_q}) - $signed({2'b00, s_out_q});
  assign d_out  = dout_s[17] ? 17'(-dout_s) : dout_s[16:0];
  assign d_in   = (e_in_q >= s_in_q) ? {1'b0, e_in_q - s_in_q} : {1'b0, s_in_q - e_in_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      // x-s_in and e_in-s_in share sign, so quotient sign is that of dout
      num_q <= 32'(d_out * (17'(x_q >= s_in_q ? x_q - s_in_q : s_in_q - x_q)));
      den_q <= d_in;
      neg_q <= dout_s[17];
    end
    if (cmd_i.div_init) begin
      rem_q <= '0; quo_q <= num_q; dcnt_q <= 6'(QW);
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {16'd0, den_q}) begin
        rem_q <= rem_sh - {16'd0, den_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
    end
  end
  assign rem_sh = {rem_q[31:0], quo_q[31]};

  always_comb begin
    res_abs = quo_q;
    if (d_in == 17'd0) r_s = $signed({18'd0, s_out_q});
    else if (neg_q) r_s = $signed({18'd0, s_out_q}) - $signed({2'b00, res_abs});
    else r_s = $signed({18'd0, s_out_q}) + $signed({2'b00, res_abs});
    if (r_s < 0) val = 16'd0;
    else if (r_s > 34'sd65535) val = 16'hFFFF;
    else val = r_s[15:0];
  end

  always_comb begin
    stat_o.opcode      = req_q.opcode;
    stat_o.preset_bad  = req_q.preset[2];
    stat_o.idx_ge_cnt  = (idx_q >= cnt_q);
    stat_o.idx_last    = ((idx_q + CntW'(1)) >= cnt_q);
    stat_o.dist_ge     = (dist_q[ia] >= req_q.distance);
    stat_o.dist_eq     = (dist_q[ia] == req_q.distance);
    stat_o.full        = (cnt_q >= CntW'(MaxPoints));
    stat_o.cnt_bad     = (cnt_q < CntW'(MinPoints)) || (cnt_q > CntW'(MaxPoints));
    stat_o.pair_bad    = (dist_q[ia] <= dist_q[ib]) || (adc_q[ia] >= adc_q[ib]);
    stat_o.bracket     = to_dist ? (x_w <= cur_in && x_w >= nxt_in)
                                 : (x_w >= cur_in && x_w <= nxt_in);
    stat_o.pre_done    = ((idx_q + CntW'(1)) >= CntW'(preset_len(req_q.preset[1:0])));
    stat_o.div_done    = (dcnt_q == 6'd0);
  end

  assign rsp_o = rsp_q;
endmodule

/* sv/plct_ctrl.sv */
// ----------------------------------------------------------------------------
// plct_ctrl
// Sequencer for insert, preset load, table check, segment scan and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            done_o,
  input  plct_pkg::stat_t stat_i,
  output plct_pkg::cmd_t  cmd_o
);
  import plct_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_FIND   = 12'b000000000100,
    S_UP     = 12'b000000001000,
    S_SHIFT  = 12'b000000010000,
    S_PRE    = 12'b000000100000,
    S_CHECK  = 12'b000001000000,
    S_SCAN   = 12'b000010000000,
    S_MUL    = 12'b000100000000,
    S_DINIT  = 12'b001000000000,
    S_DIV    = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic [CntW-1:0] slot_q, slot_d;  // insert position

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      slot_q  <= slot_d;
    end
  end

  // shift pass walks idx down from count to slot
  logic at_slot;
  logic [CntW-1:0] idx_shadow_q, idx_shadow_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_shadow_q <= '0;
    else idx_shadow_q <= idx_shadow_d;
  end
  assign at_slot = (idx_shadow_q == slot_q);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    slot_d  = slot_q;
    cmd_o   = '0;
    idx_shadow_d = idx_shadow_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          idx_shadow_d   = '0;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.opcode)
          OpInsert: state_d = S_FIND;
          OpPreset: begin
            if (stat_i.preset_bad) begin
              cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StInvalid; state_d = S_DONE;
            end else state_d = S_PRE;
          end
          default: begin
            if (stat_i.cnt_bad) begin
              cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StInvalid; state_d = S_DONE;
            end else begin
              cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
              state_d = S_CHECK;
            end
          end
        endcase
      end
      S_FIND: begin
        priority if (!stat_i.idx_ge_cnt && stat_i.dist_eq) begin
          cmd_o.adc_wr = 1'b1; cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StOk;
          state_d = S_DONE;
        end else if (stat_i.idx_ge_cnt || stat_i.dist_ge) begin
          if (stat_i.full) begin
            cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StFull; state_d = S_DONE;
          end else begin
            slot_d = idx_shadow_q;
            state_d = S_UP;
          end
        end else begin
          cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
        end
      end
      S_UP: begin
        // walk idx up to count before shifting down
        if (!stat_i.idx_ge_cnt) begin
          cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
        end else state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (!at_slot) begin
          cmd_o.shift_wr = 1'b1; cmd_o.dec_idx = 1'b1;
          idx_shadow_d = idx_shadow_q - CntW'(1);
        end else begin
          cmd_o.slot_wr = 1'b1; cmd_o.inc_cnt = 1'b1;
          cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StOk;
          state_d = S_DONE;
        end
      end
      S_PRE: begin
        cmd_o.preset_wr = 1'b1;
        if (stat_i.pre_done) begin
          cmd_o.set_cnt_pre = 1'b1;
          cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StOk;
          state_d = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
        end
      end
      S_CHECK: begin
        if (stat_i.idx_ge_cnt) begin
          cmd_o.clr_idx = 1'b1; idx_shadow_d = '0; state_d = S_SCAN;
        end else if (stat_i.pair_bad) begin
          cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StInvalid; state_d = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
        end
      end
      S_SCAN: begin
        if (stat_i.idx_last) begin
          cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StRange; state_d = S_DONE;
        end else if (stat_i.bracket) begin
          cmd_o.seg_load = 1'b1; state_d = S_MUL;
        end else begin
          cmd_o.inc_idx = 1'b1; idx_shadow_d = idx_shadow_q + CntW'(1);
        end
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1; state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1; state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.rsp_load = 1'b1; cmd_o.rsp_status = StOk; cmd_o.rsp_use_val = 1'b1;
          state_d = S_DONE;
        end else cmd_o.div_step = 1'b1;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
endmodule

/* sv/piecewise_linear_calibration_table_core.sv */
// One item at a time; the next start is taken in the cycle after the done_o
// beat at the earliest.
// Insert and preset walk the table one entry a cycle; a query scans the
// table twice (check, then segment search) and runs a 32-step serial divide.
// No result is stalled: done_o strobes one cycle with the result.
// Reset clears the point count; table entries stay undefined until written.
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_table_core
// Calibration table with sorted insert, preset load and interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_calibration_table_core_macros.svh"
module piecewise_linear_calibration_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  plct_pkg::req_t req_i,
  output logic           done_o,
  output plct_pkg::rsp_t rsp_o
);
  import plct_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_busy;

  plct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start && !busy),
    .busy_o (ctrl_busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  plct_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

  assign busy = ctrl_busy;

  `PLCT_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `PLCT_ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy)
  `PLCT_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, rsp_o.point_count <= 5'(MaxPoints))
endmodule
